/* sv/tcs_pkg.sv */
// tcs_pkg: shared types and constants of the congestion window sender
`default_nettype none

package tcs_pkg;

   localparam int SEGMENT_BYTES = 1400;
   localparam int MAX_ACK_JUMP  = 31;

   localparam int MODE_W      = 2;
   localparam int KIND_W      = 2;
   localparam int SEQ_W       = 32;
   localparam int OUT_W       = 31;
   localparam int LEN_W       = 11;
   localparam int MIN_WIN_W   = 6;
   localparam int THRESH_W    = 16;
   localparam int TOTAL_W     = 40;
   localparam int DUP_W       = 2;
   localparam int JUMP_W      = $clog2(MAX_ACK_JUMP + 1);
   localparam int SEQ_BYTES_W = SEQ_W + $clog2(SEGMENT_BYTES + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MIN_WIN_W-1:0] MIN_WIN_RESET = MIN_WIN_W'(16);
   localparam logic [THRESH_W-1:0]  THRESH_RESET  = THRESH_W'(512);
   localparam logic [DUP_W-1:0]     DUP_MAX       = DUP_W'(3);

   localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THRESH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BYTES = 2'd2;

   typedef enum logic [2:0] {
      OP_START,
      OP_ACK,
      OP_FINAL,
      OP_TIMEOUT,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [SEQ_W-1:0] ack_seq;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OUT_W-1:0]  seq_out;
      logic [LEN_W-1:0]  length;
      logic [OUT_W-1:0]  window_now;
      logic [OUT_W-1:0]  threshold_now;
      logic              finished;
      logic              last;
   } rsp_type;

   typedef struct packed {
      op_type                  op;
      logic signed [SEQ_W-1:0] ack;
   } cmd_type;

   typedef struct packed {
      logic [MIN_WIN_W-1:0] min_window;
      logic [THRESH_W-1:0]  initial_threshold;
      logic [TOTAL_W-1:0]   total_bytes;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/tcs_front.sv */
// tcs_front: input stage that accepts transactions and classifies them into commands
`default_nettype none

module tcs_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcs_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  q_push,
   output tcs_pkg::cmd_type      q_cmd
);

   localparam int SEQ_W = tcs_pkg::SEQ_W;

   logic             fr_valid_ff;
   tcs_pkg::cmd_type fr_cmd_ff;
   tcs_pkg::cmd_type fr_cmd_in;
   logic             accept;

   always_comb begin
      fr_cmd_in.ack = req_data.ack_seq;
      case (req_data.mode)
         tcs_pkg::MODE_START: fr_cmd_in.op = tcs_pkg::OP_START;
         tcs_pkg::MODE_ACK: begin
            if (req_data.ack_seq == -SEQ_W'(1))
               fr_cmd_in.op = tcs_pkg::OP_FINAL;
            else
               fr_cmd_in.op = tcs_pkg::OP_ACK;
         end
         tcs_pkg::MODE_TIMEOUT: fr_cmd_in.op = tcs_pkg::OP_TIMEOUT;
         default: fr_cmd_in.op = tcs_pkg::OP_NOP;
      endcase
   end

   assign q_push    = fr_valid_ff && !q_full;
   assign req_stall = fr_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_cmd     = fr_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else if (accept) begin
         fr_valid_ff <= 1'b1;
      end else if (q_push) begin
         fr_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_cmd_ff <= fr_cmd_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tcs_queue.sv */
// tcs_queue: short command queue between the front and back parts
`default_nettype none

module tcs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_push,
   input  wire tcs_pkg::cmd_type q_cmd,
   output logic                  q_full,
   input  wire logic             q_pop,
   output logic                  q_valid,
   output tcs_pkg::cmd_type      q_head
);

   localparam int DEPTH = tcs_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   tcs_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign q_full  = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (q_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (q_push && !q_pop)
            count_ff <= count_ff + CW'(1);
         else if (q_pop && !q_push)
            count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (count_ff < CW'(DEPTH)))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (count_ff != '0))
      else $error("command queue underflow");

endmodule

`default_nettype wire

/* sv/tcs_back.sv */
// tcs_back: window state and send sequencer with registered result output
`default_nettype none

module tcs_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tcs_pkg::cfg_type cfg,
   input  wire logic             q_valid,
   input  wire tcs_pkg::cmd_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tcs_pkg::rsp_type      rsp_data
);

   localparam int SEQ_W   = tcs_pkg::SEQ_W;
   localparam int SBW     = tcs_pkg::SEQ_BYTES_W;
   localparam int TOTAL_W = tcs_pkg::TOTAL_W;
   localparam int LEN_W   = tcs_pkg::LEN_W;
   localparam int OUT_W   = tcs_pkg::OUT_W;
   localparam int CNT_W   = tcs_pkg::MIN_WIN_W;
   localparam int JUMP_W  = tcs_pkg::JUMP_W;
   localparam int DUP_W   = tcs_pkg::DUP_W;
   localparam int SEG     = tcs_pkg::SEGMENT_BYTES;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BURST,
      S_SLOW_A,
      S_SLOW_B,
      S_LIN,
      S_LIN_CHK,
      S_REWIND,
      S_ONE,
      S_STATUS
   } state_type;

   typedef enum logic [1:0] {
      FL_SET_ONE,
      FL_ADD,
      FL_KEEP
   } flight_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   flight_type              policy_ff;
   logic [SEQ_W-1:0]        next_seq_ff;
   logic [SEQ_W-1:0]        seg_made_ff;
   logic [TOTAL_W-1:0]      bytes_sent_ff;
   logic [SBW-1:0]          seq_bytes_ff;
   logic                    fin_pending_ff;
   logic signed [SEQ_W-1:0] acked_ff;
   logic [DUP_W-1:0]        dup_ff;
   logic [SEQ_W-1:0]        window_ff;
   logic [SEQ_W-1:0]        thresh_ff;
   logic [SEQ_W-1:0]        flight_ff;
   logic                    done_ff;
   logic                    rsp_valid_ff;
   tcs_pkg::rsp_type        rsp_data_ff;

   logic                    out_free;
   logic                    in_attempt;
   logic                    att_step;
   logic                    resend;
   logic [SBW-1:0]          bytes_ext;
   logic [SBW-1:0]          resend_diff;
   logic [LEN_W-1:0]        resend_len;
   logic                    have_more;
   logic [TOTAL_W-1:0]      remain;
   logic [LEN_W-1:0]        new_len;
   logic                    att_sent;
   logic                    att_emit;
   flight_type              att_policy;
   logic [SEQ_W-1:0]        next_seq_inc;
   logic [SBW-1:0]          seq_bytes_inc;
   logic [SEQ_W-1:0]        min_ext;
   logic [SEQ_W-1:0]        half;
   logic [SEQ_W-1:0]        half_floor;
   logic [SEQ_W:0]          jump;
   logic [JUMP_W-1:0]       jump_n;
   logic                    emit;
   tcs_pkg::rsp_type        att_rsp;
   tcs_pkg::rsp_type        stat_rsp;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_attempt = (state_ff inside {S_BURST, S_SLOW_A, S_SLOW_B, S_LIN, S_ONE});
   assign att_step   = in_attempt && out_free;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;

   assign resend      = next_seq_ff < seg_made_ff;
   assign bytes_ext   = SBW'(bytes_sent_ff);
   assign resend_diff = bytes_ext - seq_bytes_ff;
   assign resend_len  = (bytes_ext <= seq_bytes_ff) ? '0 :
                        (resend_diff > SBW'(SEG)) ? LEN_W'(SEG) : resend_diff[LEN_W-1:0];
   assign have_more   = bytes_sent_ff < cfg.total_bytes;
   assign remain      = cfg.total_bytes - bytes_sent_ff;
   assign new_len     = (remain > TOTAL_W'(SEG)) ? LEN_W'(SEG) : remain[LEN_W-1:0];
   assign att_sent    = resend || (!fin_pending_ff && have_more);
   assign att_emit    = resend || fin_pending_ff || have_more;

   assign next_seq_inc  = next_seq_ff + SEQ_W'(1);
   assign seq_bytes_inc = (next_seq_ff == '1) ? '0 : seq_bytes_ff + SBW'(SEG);

   assign min_ext    = SEQ_W'(cfg.min_window);
   assign half       = window_ff >> 1;
   assign half_floor = (half < min_ext) ? min_ext : half;

   assign jump   = {q_head.ack[SEQ_W-1], q_head.ack} - {acked_ff[SEQ_W-1], acked_ff};
   assign jump_n = (jump > (SEQ_W + 1)'(tcs_pkg::MAX_ACK_JUMP)) ?
                   JUMP_W'(tcs_pkg::MAX_ACK_JUMP) : jump[JUMP_W-1:0];

   always_comb begin
      case (state_ff)
         S_BURST: att_policy = FL_SET_ONE;
         S_ONE:   att_policy = policy_ff;
         default: att_policy = FL_ADD;
      endcase
   end

   always_comb begin
      att_rsp               = '0;
      att_rsp.kind          = att_sent ? tcs_pkg::KIND_DATA : tcs_pkg::KIND_END;
      att_rsp.seq_out       = att_sent ? next_seq_ff[OUT_W-1:0] : '0;
      att_rsp.length        = resend ? resend_len : (att_sent ? new_len : '0);
      stat_rsp              = '0;
      stat_rsp.kind         = tcs_pkg::KIND_STATUS;
      stat_rsp.window_now   = window_ff[OUT_W-1:0];
      stat_rsp.threshold_now = thresh_ff[OUT_W-1:0];
      stat_rsp.finished     = done_ff;
      stat_rsp.last         = 1'b1;
   end

   assign emit = (att_step && att_emit) || ((state_ff == S_STATUS) && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         policy_ff      <= FL_KEEP;
         next_seq_ff    <= '0;
         seg_made_ff    <= '0;
         bytes_sent_ff  <= '0;
         seq_bytes_ff   <= '0;
         fin_pending_ff <= 1'b0;
         acked_ff       <= -SEQ_W'(1);
         dup_ff         <= '0;
         window_ff      <= SEQ_W'(1);
         thresh_ff      <= SEQ_W'(tcs_pkg::THRESH_RESET);
         flight_ff      <= '0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (att_step) begin
            if (resend) begin
               next_seq_ff  <= next_seq_inc;
               seq_bytes_ff <= seq_bytes_inc;
            end else if (!fin_pending_ff) begin
               if (!have_more) begin
                  fin_pending_ff <= 1'b1;
               end else begin
                  bytes_sent_ff <= bytes_sent_ff + TOTAL_W'(new_len);
                  seg_made_ff   <= next_seq_inc;
                  next_seq_ff   <= next_seq_inc;
                  seq_bytes_ff  <= seq_bytes_inc;
               end
            end
            case (att_policy)
               FL_SET_ONE: flight_ff <= SEQ_W'(1);
               FL_ADD:     flight_ff <= flight_ff + SEQ_W'(att_sent);
               default:    flight_ff <= flight_ff;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  case (q_head.op)
                     tcs_pkg::OP_START: begin
                        next_seq_ff    <= '0;
                        seg_made_ff    <= '0;
                        bytes_sent_ff  <= '0;
                        seq_bytes_ff   <= '0;
                        fin_pending_ff <= 1'b0;
                        acked_ff       <= -SEQ_W'(1);
                        dup_ff         <= '0;
                        window_ff      <= SEQ_W'(1);
                        thresh_ff      <= SEQ_W'(cfg.initial_threshold);
                        flight_ff      <= '0;
                        done_ff        <= 1'b0;
                        cnt_ff         <= cfg.min_window;
                        state_ff       <= (cfg.min_window == '0) ? S_STATUS : S_BURST;
                     end
                     tcs_pkg::OP_TIMEOUT: begin
                        if (done_ff) begin
                           state_ff <= S_STATUS;
                        end else begin
                           thresh_ff   <= half_floor;
                           window_ff   <= min_ext;
                           next_seq_ff <= $unsigned(acked_ff) + SEQ_W'(1);
                           policy_ff   <= FL_SET_ONE;
                           state_ff    <= S_REWIND;
                        end
                     end
                     tcs_pkg::OP_FINAL: begin
                        done_ff  <= 1'b1;
                        state_ff <= S_STATUS;
                     end
                     tcs_pkg::OP_ACK: begin
                        if (done_ff) begin
                           state_ff <= S_STATUS;
                        end else if (q_head.ack > acked_ff) begin
                           dup_ff    <= DUP_W'(1);
                           flight_ff <= flight_ff - SEQ_W'(jump_n);
                           acked_ff  <= q_head.ack;
                           cnt_ff    <= CNT_W'(jump_n);
                           state_ff  <= (window_ff < thresh_ff) ? S_SLOW_A : S_LIN;
                        end else if ((q_head.ack == acked_ff) &&
                                     (dup_ff == tcs_pkg::DUP_MAX - DUP_W'(1))) begin
                           dup_ff      <= tcs_pkg::DUP_MAX;
                           thresh_ff   <= half_floor;
                           window_ff   <= half_floor;
                           next_seq_ff <= $unsigned(q_head.ack) + SEQ_W'(1);
                           policy_ff   <= FL_KEEP;
                           state_ff    <= S_REWIND;
                        end else begin
                           if ((q_head.ack == acked_ff) && (dup_ff < tcs_pkg::DUP_MAX))
                              dup_ff <= dup_ff + DUP_W'(1);
                           state_ff <= S_STATUS;
                        end
                     end
                     default: state_ff <= S_STATUS;
                  endcase
               end
            end
            S_BURST: begin
               if (out_free) begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) state_ff <= S_STATUS;
               end
            end
            S_SLOW_A: begin
               if (out_free) begin
                  window_ff <= window_ff + SEQ_W'(1);
                  state_ff  <= S_SLOW_B;
               end
            end
            S_SLOW_B: begin
               if (out_free) begin
                  cnt_ff   <= cnt_ff - CNT_W'(1);
                  state_ff <= (cnt_ff == CNT_W'(1)) ? S_STATUS : S_SLOW_A;
               end
            end
            S_LIN: begin
               if (out_free) begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) state_ff <= S_LIN_CHK;
               end
            end
            S_LIN_CHK: begin
               if (flight_ff == window_ff) begin
                  window_ff <= window_ff + SEQ_W'(1);
                  policy_ff <= FL_ADD;
                  state_ff  <= S_ONE;
               end else begin
                  state_ff <= S_STATUS;
               end
            end
            S_REWIND: begin
               seq_bytes_ff <= SBW'(next_seq_ff) * SBW'(SEG);
               state_ff     <= S_ONE;
            end
            S_ONE: begin
               if (out_free) state_ff <= S_STATUS;
            end
            S_STATUS: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= (state_ff == S_STATUS) ? stat_rsp : att_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_STATUS) && out_free) |=>
         (rsp_valid_ff && rsp_data_ff.last && (state_ff == S_IDLE)))
      else $error("status transaction did not close the item");

   a_rewind_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REWIND) |=>
         ((state_ff == S_ONE) && (seq_bytes_ff == SBW'($past(next_seq_ff)) * SBW'(SEG))))
      else $error("byte offset not rebuilt after rewind");

   a_send_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind != tcs_pkg::KIND_STATUS)) |->
         (!rsp_data_ff.last && (rsp_data_ff.window_now == '0) && !rsp_data_ff.finished))
      else $error("send transaction carries status fields");

endmodule

`default_nettype wire

/* sv/tcp_style_congestion_sender.sv */
// tcp_style_congestion_sender: top level with configuration registers
//
// Usage: the req channel takes one transaction per event (mode 0 start,
// 1 acknowledgement with ack_seq, -1 meaning final, 2 timeout, 3 no-op).
// The rsp channel returns zero or more send transactions (data segment with
// sequence and length, or end message) followed by one status transaction
// flagged last, carrying window, threshold and the finished flag.
// Configuration is written through csr_we/csr_index/csr_wdata while idle.
// A request is registered in the input stage and then in the queue
// before the sequencer takes it. The sequencer takes the command, then
// makes its send attempts (start: min_window attempts; ack
// in slow start: 2 per acked segment, the window step made with the first;
// ack at or above threshold: one per acked segment, plus one check and
// possibly one more attempt), rebuilds the byte offset on a timeout
// or fast retransmit, and closes with the status. It makes one send attempt
// per cycle while rsp is not stalled. New requests are
// accepted into the two-entry queue while the sequencer works.
// Reset clears the window state to its idle values and loads the register
// defaults. A stalled rsp holds the output register and the sequencer waits.
`default_nettype none

module tcp_style_congestion_sender (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire tcs_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output tcs_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [tcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tcs_pkg::cfg_type cfg_ff;
   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   tcs_pkg::cmd_type q_cmd;
   tcs_pkg::cmd_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_window        <= tcs_pkg::MIN_WIN_RESET;
         cfg_ff.initial_threshold <= tcs_pkg::THRESH_RESET;
         cfg_ff.total_bytes       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tcs_pkg::CSR_MIN_WINDOW:
               cfg_ff.min_window <= csr_wdata[tcs_pkg::MIN_WIN_W-1:0];
            tcs_pkg::CSR_INIT_THRESH:
               cfg_ff.initial_threshold <= csr_wdata[tcs_pkg::THRESH_W-1:0];
            tcs_pkg::CSR_TOTAL_BYTES:
               cfg_ff.total_bytes <= csr_wdata[tcs_pkg::TOTAL_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   tcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   tcs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   tcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* tb/congestion_window_monitor.sv */
// congestion_window_monitor: predicts the sender's transactions and compares them with the block
`timescale 1ns / 100ps

module congestion_window_monitor import tcs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         pending
);

   cfg_type        cfg;
   logic [31:0]    nxt_seq;
   logic [31:0]    seg_count;
   logic [39:0]    sent_bytes;
   bit             fin_wait;
   longint         ack_mark;
   int             dup_n;
   logic [31:0]    win;
   logic [31:0]    ssthresh;
   logic [31:0]    flight;
   bit             xfer_done;
   rsp_type        awaited_msgs[$];

   function automatic void post(logic [KIND_W-1:0] kind, logic [OUT_W-1:0] seq,
                                logic [LEN_W-1:0] len, logic [OUT_W-1:0] w,
                                logic [OUT_W-1:0] t, logic fin, logic lst);
      rsp_type r;
      r.kind          = kind;
      r.seq_out       = seq;
      r.length        = len;
      r.window_now    = w;
      r.threshold_now = t;
      r.finished      = fin;
      r.last          = lst;
      awaited_msgs.push_back(r);
   endfunction

   function automatic void restart_transfer();
      nxt_seq    = '0;
      seg_count  = '0;
      sent_bytes = '0;
      fin_wait   = 1'b0;
      ack_mark   = -1;
      dup_n      = 0;
      win        = 32'd1;
      ssthresh   = 32'(cfg.initial_threshold);
      flight     = '0;
      xfer_done  = 1'b0;
   endfunction

   function automatic logic [31:0] at_least_floor(logic [31:0] v);
      return (v < 32'(cfg.min_window)) ? 32'(cfg.min_window) : v;
   endfunction

   // one send attempt: resend, new segment, end message, or none when data first runs out
   function automatic bit try_send();
      logic [63:0] seg_start;
      logic [63:0] len;
      if (nxt_seq < seg_count) begin
         seg_start = 64'(nxt_seq) * SEGMENT_BYTES;
         len = '0;
         if (64'(sent_bytes) > seg_start) begin
            len = 64'(sent_bytes) - seg_start;
            if (len > SEGMENT_BYTES) len = SEGMENT_BYTES;
         end
         post(KIND_DATA, nxt_seq[OUT_W-1:0], len[LEN_W-1:0], '0, '0, 1'b0, 1'b0);
         nxt_seq = nxt_seq + 32'd1;
         return 1'b1;
      end
      if (!fin_wait) begin
         if (sent_bytes >= cfg.total_bytes) begin
            fin_wait = 1'b1;
            return 1'b0;
         end
         len = 64'(cfg.total_bytes) - 64'(sent_bytes);
         if (len > SEGMENT_BYTES) len = SEGMENT_BYTES;
         sent_bytes = sent_bytes + len[39:0];
         seg_count  = nxt_seq + 32'd1;
         post(KIND_DATA, nxt_seq[OUT_W-1:0], len[LEN_W-1:0], '0, '0, 1'b0, 1'b0);
         nxt_seq = nxt_seq + 32'd1;
         return 1'b1;
      end
      post(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
      return 1'b0;
   endfunction

   function automatic void predict_sends(req_type rq);
      longint ack;
      longint jump;
      int     n;
      int     i;
      ack = $signed({{32{rq.ack_seq[31]}}, rq.ack_seq});
      case (rq.mode)
         MODE_START: begin
            restart_transfer();
            for (i = 0; i < cfg.min_window; i++) begin
               void'(try_send());
               flight = 32'd1;
            end
         end
         MODE_TIMEOUT: begin
            if (!xfer_done) begin
               ssthresh = at_least_floor(win / 32'd2);
               win      = 32'(cfg.min_window);
               nxt_seq  = 32'(ack_mark + 1);
               void'(try_send());
               flight = 32'd1;
            end
         end
         MODE_ACK: begin
            if (xfer_done) begin
            end else if (ack == -1) begin
               xfer_done = 1'b1;
            end else if (ack > ack_mark) begin
               jump = ack - ack_mark;
               if (jump > MAX_ACK_JUMP) jump = MAX_ACK_JUMP;
               n        = int'(jump);
               dup_n    = 1;
               flight   = flight - 32'(n);
               ack_mark = ack;
               if (win < ssthresh) begin
                  for (i = 0; i < n; i++) begin
                     win    = win + 32'd1;
                     flight = flight + 32'(try_send());
                     flight = flight + 32'(try_send());
                  end
               end else begin
                  for (i = 0; i < n; i++) flight = flight + 32'(try_send());
                  if (flight == win) begin
                     win    = win + 32'd1;
                     flight = flight + 32'(try_send());
                  end
               end
            end else if (ack == ack_mark) begin
               // third copy of one number triggers fast retransmit
               if (dup_n < DUP_MAX) begin
                  dup_n++;
                  if (dup_n == DUP_MAX) begin
                     ssthresh = at_least_floor(win / 32'd2);
                     win      = at_least_floor(win / 32'd2);
                     nxt_seq  = 32'(ack + 1);
                     void'(try_send());
                  end
               end
            end
         end
         default: begin
         end
      endcase
      post(KIND_STATUS, '0, '0, win[OUT_W-1:0], ssthresh[OUT_W-1:0], xfer_done, 1'b1);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.min_window        = MIN_WIN_RESET;
         cfg.initial_threshold = THRESH_RESET;
         cfg.total_bytes       = '0;
         restart_transfer();
         awaited_msgs.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_WINDOW:  cfg.min_window        = csr_wdata[MIN_WIN_W-1:0];
               CSR_INIT_THRESH: cfg.initial_threshold = csr_wdata[THRESH_W-1:0];
               CSR_TOTAL_BYTES: cfg.total_bytes       = csr_wdata[TOTAL_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) predict_sends(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_msgs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: unexpected transaction %p", $time, rsp_data);
            end else begin
               want = awaited_msgs.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.seq_out !== want.seq_out ||
                   rsp_data.length !== want.length ||
                   rsp_data.window_now !== want.window_now ||
                   rsp_data.threshold_now !== want.threshold_now ||
                   rsp_data.finished !== want.finished || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: transaction mismatch", $time);
                     $display("   expected %p", want);
                     $display("   actual   %p", rsp_data);
                  end
               end
            end
         end
      end
      pending = awaited_msgs.size();
   end

endmodule

/* tb/tcp_style_congestion_sender_tb.sv */
// tcp_style_congestion_sender_tb: stimulus, flow control and verdict for the window sender
`timescale 1ns / 100ps

module tcp_style_congestion_sender_tb;
   import tcs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
   localparam int LATENCY     = 80;
   localparam int HOLD_CYCLES = 250;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 57;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   int                    mismatches;
   int                    pending;
   bit                    quiet       = 1'b0;
   int                    hold_asks   = 0;
   int                    holds_done  = 0;
   int                    hold_left   = 0;
   int                    stuck       = 0;

   tcp_style_congestion_sender uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   congestion_window_monitor monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != holds_done) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         holds_done <= hold_asks;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 15);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else if (stuck == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   task automatic offer(input logic [MODE_W-1:0] m, input logic [31:0] a);
      bit taken;
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data  <= {m, a};
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic program_regs(input logic [MIN_WIN_W-1:0] mw,
                               input logic [THRESH_W-1:0] th,
                               input logic [TOTAL_W-1:0] tot);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_WINDOW;
      csr_wdata <= CSR_DATA_W'(mw);
      @(posedge clock);
      csr_index <= CSR_INIT_THRESH;
      csr_wdata <= CSR_DATA_W'(th);
      @(posedge clock);
      csr_index <= CSR_TOTAL_BYTES;
      csr_wdata <= CSR_DATA_W'(tot);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed transfers: start, advancing acks, duplicates, timeouts, close
   task automatic run_transfers(input int count, input bit pressure);
      int          i;
      int          pick;
      longint      cursor;
      longint      v;
      bit          ended;
      logic [31:0] a;
      cursor = -1;
      ended  = 1'b0;
      offer(MODE_START, $urandom());
      for (i = 1; i < count; i++) begin
         if (pressure && i == 12) hold_asks <= hold_asks + 1;
         pick = $urandom_range(0, 99);
         if (ended && $urandom_range(0, 2) == 0) pick = 0;
         if (pick < 5) begin
            cursor = -1;
            ended  = 1'b0;
            offer(MODE_START, $urandom());
         end else if (pick < 60) begin
            if (pick < 55) cursor = cursor + longint'($urandom_range(1, 3));
            else cursor = cursor + longint'($urandom_range(4, 45));
            if (cursor > 64'h7FFF_FFFF) cursor = 64'h7FFF_FFFF;
            offer(MODE_ACK, 32'(cursor));
         end else if (pick < 73) begin
            if (cursor < 0) cursor = 0;
            offer(MODE_ACK, 32'(cursor));
         end else if (pick < 77) begin
            v = cursor - longint'($urandom_range(1, 6));
            if (v == -1) ended = 1'b1;
            offer(MODE_ACK, 32'(v));
         end else if (pick < 85) begin
            offer(MODE_TIMEOUT, $urandom());
         end else if (pick < 88) begin
            ended = 1'b1;
            offer(MODE_ACK, '1);
         end else if (pick < 92) begin
            offer(MODE_NOP, $urandom());
         end else if (pick < 98) begin
            offer(($urandom_range(0, 1) == 0) ? MODE_TIMEOUT : MODE_NOP, $urandom());
         end else begin
            a = $urandom();
            v = longint'($signed(a));
            if (v == -1) ended = 1'b1;
            else if (v > cursor) cursor = v;
            offer(MODE_ACK, a);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      program_regs(6'd4, 16'd8, 40'd10000);
      offer(MODE_START, 32'h0);
      offer(MODE_ACK, 32'd0);
      offer(MODE_ACK, 32'd2);
      offer(MODE_ACK, 32'd2);
      offer(MODE_ACK, 32'd2);
      offer(MODE_ACK, 32'd2);
      offer(MODE_ACK, 32'd1);
      offer(MODE_ACK, 32'hFFFF_FFFB);
      offer(MODE_TIMEOUT, 32'hFFFF_FFFF);
      offer(MODE_ACK, 32'd40);
      offer(MODE_ACK, 32'h7FFF_FFFF);
      offer(MODE_NOP, 32'h5555_5555);
      offer(MODE_TIMEOUT, 32'hAAAA_AAAA);
      offer(MODE_ACK, 32'hFFFF_FFFF);
      offer(MODE_ACK, 32'd50);
      offer(MODE_TIMEOUT, 32'h0);
      offer(MODE_START, 32'h8000_0000);
      offer(MODE_ACK, 32'h8000_0000);
      offer(MODE_ACK, 32'd3);
      offer(MODE_ACK, 32'd3);
      offer(MODE_ACK, 32'd3);
      offer(MODE_ACK, 32'd9);
      drain();

      program_regs(6'd0, 16'd1, 40'd0);
      run_transfers(PHASE_ITEMS, 1'b0);
      drain();

      program_regs(6'd63, 16'hFFFF, 40'hFF_FFFF_FFFF);
      run_transfers(PHASE_ITEMS, 1'b1);
      drain();

      quiet <= 1'b1;
      program_regs(6'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
                   40'($urandom_range(0, 40000)));
      run_transfers(PHASE_ITEMS, 1'b0);
      drain();
      quiet <= 1'b0;

      program_regs(6'd1, 16'd2, 40'd5000);
      run_transfers(PHASE_ITEMS, 1'b0);
      drain();

      program_regs(6'($urandom_range(1, 16)), 16'($urandom_range(1, 65535)),
                   40'($urandom_range(0, 200000)));
      run_transfers(PHASE_ITEMS, 1'b1);
      drain();

      program_regs(6'd32, 16'($urandom_range(1, 100)), 40'($urandom_range(0, 3000000)));
      run_transfers(PHASE_ITEMS, 1'b0);
      drain();

      if (mismatches == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
